// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for the RTL of the station detection table.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/sdt_pkg.sv -----
// Package for the station detection table: sizes, beat payload types,
// status codes and the token that walks the cell chain. No dependencies.
`default_nettype none

package sdt_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
  localparam int ENTRY_IDX_W   = 6;

  typedef enum logic [1:0] {
    ST_UPDATED  = 2'd0,
    ST_INSERTED = 2'd1,
    ST_DROPPED  = 2'd2
  } status_t;

  typedef struct packed {
    logic [47:0]        station_mac;
    logic signed [7:0]  signal_strength;
    logic [3:0]         radio_channel;
    logic [31:0]        time_ms;
    logic [5:0]         signature_index;
    logic               name_present;
  } obs_t;

  typedef struct packed {
    status_t                  status;
    logic [ENTRY_IDX_W-1:0]   entry_index;
    logic [31:0]              seen_count;
    logic signed [7:0]        peak_strength;
    logic [31:0]              first_seen_ms;
    logic                     adopt_name;
  } result_t;

  // Token handed from cell to cell. remaining counts occupied slots still
  // ahead of the token; idx is the slot the token is at (or finished at).
  typedef struct packed {
    obs_t               obs;
    logic [CNT_W-1:0]   remaining;
    logic [IDX_W-1:0]   idx;
    logic               done;
    status_t            status;
    logic [31:0]        count;
    logic signed [7:0]  peak;
    logic [31:0]        first;
    logic               adopt;
  } token_t;

  // Slot number modulo 64, for the result beat.
  function automatic logic [ENTRY_IDX_W-1:0] to_entry_index(input logic [IDX_W-1:0] idx);
    logic [IDX_W+ENTRY_IDX_W-1:0] wide;
    wide = {{ENTRY_IDX_W{1'b0}}, idx};
    return wide[ENTRY_IDX_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/sdt_cell.sv -----
// One slot of the station table: holds a single entry and passes the
// lookup token on to the next slot. Depends on sdt_pkg.
`default_nettype none

module sdt_cell
  import sdt_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   advance,
  input  wire logic   vld_i,
  input  wire token_t tok_i,
  output logic        vld_o,
  output token_t      tok_o
);

  // Entry contents
  logic [47:0]       mac_r;
  logic [31:0]       count_r;
  logic signed [7:0] peak_r;
  logic [3:0]        channel_r;
  logic [31:0]       first_time_r;
  logic [31:0]       last_time_r;
  logic [5:0]        signature_r;
  logic              name_known_r;

  logic              vld_r;
  token_t            tok_r;
  token_t            tok_nxt;

  logic              occ;
  logic              hit;
  logic              ins;
  logic [31:0]       count_nxt;
  logic signed [7:0] peak_nxt;
  logic              adopt_nxt;

  always_comb begin
    occ       = (tok_i.remaining != '0);
    hit       = vld_i && !tok_i.done && occ && (mac_r == tok_i.obs.station_mac);
    ins       = vld_i && !tok_i.done && !occ;
    count_nxt = (count_r == '1) ? count_r : count_r + 32'd1;
    peak_nxt  = ($signed(tok_i.obs.signal_strength) > $signed(peak_r)) ?
                tok_i.obs.signal_strength : peak_r;
    adopt_nxt = !name_known_r && tok_i.obs.name_present;

    tok_nxt           = tok_i;
    tok_nxt.remaining = occ ? tok_i.remaining - CNT_W'(1) : '0;
    tok_nxt.idx       = (hit || ins || tok_i.done) ? tok_i.idx : tok_i.idx + IDX_W'(1);
    if (hit) begin
      tok_nxt.done   = 1'b1;
      tok_nxt.status = ST_UPDATED;
      tok_nxt.count  = count_nxt;
      tok_nxt.peak   = peak_nxt;
      tok_nxt.first  = first_time_r;
      tok_nxt.adopt  = adopt_nxt;
    end else if (ins) begin
      tok_nxt.done   = 1'b1;
      tok_nxt.status = ST_INSERTED;
      tok_nxt.count  = 32'd1;
      tok_nxt.peak   = tok_i.obs.signal_strength;
      tok_nxt.first  = tok_i.obs.time_ms;
      tok_nxt.adopt  = tok_i.obs.name_present;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && ins) begin
      mac_r        <= tok_i.obs.station_mac;
      count_r      <= 32'd1;
      peak_r       <= tok_i.obs.signal_strength;
      channel_r    <= tok_i.obs.radio_channel;
      first_time_r <= tok_i.obs.time_ms;
      last_time_r  <= tok_i.obs.time_ms;
      signature_r  <= tok_i.obs.signature_index;
      name_known_r <= tok_i.obs.name_present;
    end else if (advance && hit) begin
      count_r      <= count_nxt;
      peak_r       <= peak_nxt;
      channel_r    <= tok_i.obs.radio_channel;
      last_time_r  <= tok_i.obs.time_ms;
      name_known_r <= name_known_r | adopt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (advance) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      tok_r <= tok_nxt;
    end
  end

  assign vld_o = vld_r;
  assign tok_o = tok_r;

endmodule

`default_nettype wire

// ----- hw/rtl/station_detection_table.sv -----
// Station detection table: keeps up to TABLE_ENTRIES stations keyed by MAC.
// Each accepted observation is carried as a token along a row of
// TABLE_ENTRIES cells, one cell per clock while the row is not held, each
// cell holding one slot; the first occupied cell with the same MAC updates
// its entry, otherwise the first free cell takes a new entry, and a token
// that leaves the row unclaimed reports a full table. An item reaches its
// result beat through the register of each cell and then the output register.
// in_stall stays high until the result has moved into the output register,
// so a new item is not accepted while the last one is still in the row.
// The next item can be taken while that beat still waits on out_stall.
// Depends on sdt_pkg, sdt_cell and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module station_detection_table
  import sdt_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire obs_t    in_data,
  output logic         out_valid,
  input  wire logic    out_stall,
  output result_t      out_data
);

  logic             busy_r;
  logic             busy_nxt;
  logic [CNT_W-1:0] occupied_r;
  logic [CNT_W-1:0] occupied_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  result_t          out_data_r;
  result_t          tail_res;

  logic             in_take;
  logic             load_out;
  logic             advance;
  logic             tail_ins;

  logic             vld_chain [TABLE_ENTRIES+1];
  token_t           tok_chain [TABLE_ENTRIES+1];

  assign in_stall = busy_r;
  assign in_take  = in_valid && !busy_r;

  // Launch the token at the head of the row.
  always_comb begin
    vld_chain[0]           = in_take;
    tok_chain[0]           = '0;
    tok_chain[0].obs       = in_data;
    tok_chain[0].remaining = occupied_r;
    tok_chain[0].status    = ST_DROPPED;
  end

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    sdt_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .advance (advance),
      .vld_i   (vld_chain[g]),
      .tok_i   (tok_chain[g]),
      .vld_o   (vld_chain[g+1]),
      .tok_o   (tok_chain[g+1])
    );
  end

  // Hold the whole row while the tail beat cannot move to the output.
  assign load_out = vld_chain[TABLE_ENTRIES] && (!out_valid_r || !out_stall);
  assign advance  = !vld_chain[TABLE_ENTRIES] || load_out;
  assign tail_ins = tok_chain[TABLE_ENTRIES].done &&
                    (tok_chain[TABLE_ENTRIES].status == ST_INSERTED);

  always_comb begin
    tail_res = '0;
    tail_res.status = ST_DROPPED;
    if (tok_chain[TABLE_ENTRIES].done) begin
      tail_res.status        = tok_chain[TABLE_ENTRIES].status;
      tail_res.entry_index   = to_entry_index(tok_chain[TABLE_ENTRIES].idx);
      tail_res.seen_count    = tok_chain[TABLE_ENTRIES].count;
      tail_res.peak_strength = tok_chain[TABLE_ENTRIES].peak;
      tail_res.first_seen_ms = tok_chain[TABLE_ENTRIES].first;
      tail_res.adopt_name    = tok_chain[TABLE_ENTRIES].adopt;
    end
  end

  always_comb begin
    busy_nxt      = busy_r;
    occupied_nxt  = occupied_r;
    out_valid_nxt = out_valid_r;
    if (in_take) begin
      busy_nxt = 1'b1;
    end
    if (load_out) begin
      busy_nxt      = 1'b0;
      out_valid_nxt = 1'b1;
      if (tail_ins) begin
        occupied_nxt = occupied_r + CNT_W'(1);
      end
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      occupied_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      occupied_r  <= occupied_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= tail_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_ALWAYS(a_occ_bound, occupied_r <= CNT_W'(TABLE_ENTRIES), "occupied count above table size")
  `ASSERT_IMPLIES(a_tail_busy, vld_chain[TABLE_ENTRIES], busy_r, "token in row while idle")
  `ASSERT_NEXT(a_ins_grows, load_out && tail_ins, occupied_r == $past(occupied_r) + CNT_W'(1), "insert did not grow table")
  `ASSERT_IMPLIES(a_drop_full, load_out && !tok_chain[TABLE_ENTRIES].done, occupied_r == CNT_W'(TABLE_ENTRIES), "drop with free slot")

endmodule

`default_nettype wire
